[rtl/pltc_pkg.sv]
// Package for the piecewise-linear tone curve block.
// Holds the shared item types, register codes, reset knots and the divider step.
// No dependencies.
`timescale 1ns / 1ps

package pltc_pkg;

    localparam int REG_W       = 48;
    localparam int BYTE_W      = 8;
    localparam int MAX_KNOTS   = 8;
    localparam int EXT_W       = MAX_KNOTS * BYTE_W;
    localparam int CFG_IDX_W   = 2;
    localparam int QUO_W       = 8;
    localparam int QUO_IDX_W   = $clog2(QUO_W);
    localparam int PROD_W      = 16;
    localparam int DIV_STAGES  = 4;
    localparam int DIV_BITS    = QUO_W / DIV_STAGES;
    localparam int QUEUE_DEPTH = 4;
    // front register + queue + product stage + divider stages + output register
    localparam int OCC_MAX     = 1 + QUEUE_DEPTH + 1 + DIV_STAGES + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_KNOTS    = 2'd0,
        REG_RED_KNOTS  = 2'd1,
        REG_BLUE_KNOTS = 2'd2
    } cfg_reg_t;

    localparam logic [REG_W-1:0] X_KNOTS_RESET    = 48'd281236981690880;
    localparam logic [REG_W-1:0] RED_KNOTS_RESET  = 48'd281020971094400;
    localparam logic [REG_W-1:0] BLUE_KNOTS_RESET = 48'd281323555409920;

    // One channel after segment lookup: result = base +/- (mag * dv) / den
    typedef struct packed {
        logic [7:0] base;
        logic       neg;
        logic [7:0] mag;
        logic [7:0] dv;
        logic [7:0] den;
    } lane_t;

    typedef struct packed {
        logic [7:0] green;
        logic       invalid;
        lane_t      red;
        lane_t      blue;
    } item_t;

    typedef struct packed {
        logic [7:0]        base;
        logic              neg;
        logic [7:0]        den;
        logic [PROD_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
    } div_t;

    typedef struct packed {
        logic [7:0] green;
        logic       invalid;
        div_t       red;
        div_t       blue;
    } back_t;

    // One restoring division step at quotient bit pos
    function automatic div_t div_step(input div_t d, input int unsigned pos);
        div_t              r;
        logic [PROD_W-1:0] sub;
        r   = d;
        sub = PROD_W'(d.den) << pos;
        if (d.rem >= sub)
        begin
            r.rem                  = d.rem - sub;
            r.quo[QUO_IDX_W'(pos)] = 1'b1;
        end
        return r;
    endfunction

endpackage

[rtl/pltc_front.sv]
// Front end of the tone curve: knot registers, knot check and segment lookup.
// Registers one classified pixel and hands it to the queue. Uses pltc_pkg.
`timescale 1ns / 1ps

module pltc_front
    import pltc_pkg::*;
#(
    parameter int KNOT_COUNT = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           blue_in,
    input  logic [7:0]           green_in,
    input  logic [7:0]           red_in,
    output logic                 push,
    input  logic                 push_ready,
    output item_t                push_item
);

    localparam int IDX_W = (KNOT_COUNT > 1) ? $clog2(KNOT_COUNT) : 1;

    typedef logic [KNOT_COUNT-1:0][7:0] knot_vec_t;

    logic [REG_W-1:0] x_knots_reg;
    logic [REG_W-1:0] red_knots_reg;
    logic [REG_W-1:0] blue_knots_reg;
    logic             item_valid_reg;
    logic             item_valid_next;
    item_t            item_reg;
    item_t            item_next;
    logic [EXT_W-1:0] x_ext;
    logic [EXT_W-1:0] r_ext;
    logic [EXT_W-1:0] b_ext;
    knot_vec_t        xb;
    knot_vec_t        rb;
    knot_vec_t        bb;
    logic             knots_ok;
    logic             accept;

    function automatic lane_t classify(input logic [7:0] v, input knot_vec_t xk,
                                       input knot_vec_t yk, input logic ok);
        lane_t            r;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] jm;
        logic             found;
        logic [8:0]       dy;
        logic [7:0]       x0;
        logic [7:0]       x1;
        logic [7:0]       y0;
        logic [7:0]       y1;
        j     = IDX_W'(KNOT_COUNT - 1);
        found = 1'b0;
        for (int k = 0; k < KNOT_COUNT - 1; k++)
        begin
            if (!found && xk[k] >= v)
            begin
                j     = IDX_W'(k);
                found = 1'b1;
            end
        end
        jm     = (j == '0) ? '0 : j - 1'b1;
        x1     = xk[j];
        y1     = yk[j];
        x0     = xk[jm];
        y0     = yk[jm];
        r.base = ok ? y1 : v;
        r.neg  = 1'b0;
        r.mag  = '0;
        r.dv   = '0;
        r.den  = 8'd1;
        dy     = '0;
        if (ok && j != '0 && x1 != v)
        begin
            dy     = {1'b0, y1} - {1'b0, y0};
            r.base = y0;
            r.neg  = dy[8];
            r.mag  = dy[8] ? 8'(-dy) : dy[7:0];
            r.dv   = v - x0;
            r.den  = x1 - x0;
        end
        return r;
    endfunction

    always_comb
    begin
        x_ext = {{(EXT_W - REG_W){1'b0}}, x_knots_reg};
        r_ext = {{(EXT_W - REG_W){1'b0}}, red_knots_reg};
        b_ext = {{(EXT_W - REG_W){1'b0}}, blue_knots_reg};
        for (int k = 0; k < KNOT_COUNT; k++)
        begin
            xb[k] = x_ext[k * BYTE_W +: BYTE_W];
            rb[k] = r_ext[k * BYTE_W +: BYTE_W];
            bb[k] = b_ext[k * BYTE_W +: BYTE_W];
        end
        knots_ok = (xb[0] == 8'd0) && (xb[KNOT_COUNT-1] == 8'hFF);
        for (int k = 1; k < KNOT_COUNT; k++)
        begin
            if (xb[k] <= xb[k-1])
                knots_ok = 1'b0;
        end
    end

    assign push     = item_valid_reg && push_ready;
    assign in_stall = item_valid_reg && !push_ready;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next   = accept || (item_valid_reg && !push);
        item_next.green   = green_in;
        item_next.invalid = !knots_ok;
        item_next.red     = classify(red_in, xb, rb, knots_ok);
        item_next.blue    = classify(blue_in, xb, bb, knots_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_knots_reg    <= X_KNOTS_RESET;
            red_knots_reg  <= RED_KNOTS_RESET;
            blue_knots_reg <= BLUE_KNOTS_RESET;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_X_KNOTS:    x_knots_reg    <= cfg_data;
                    REG_RED_KNOTS:  red_knots_reg  <= cfg_data;
                    REG_BLUE_KNOTS: blue_knots_reg <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

    assign push_item = item_reg;

endmodule

[rtl/pltc_fifo.sv]
// Short queue between the front end and the arithmetic back end.
// Flop storage, one write and one read port. Uses pltc_pkg.
`timescale 1ns / 1ps

module pltc_fifo
    import pltc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  push_ready,
    input  item_t push_item,
    input  logic  pop,
    output logic  pop_valid,
    output item_t pop_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[rtl/pltc_back.sv]
// Back end of the tone curve: product stage, pipelined restoring divider and
// the output register with its stall handling. Uses pltc_pkg.
`timescale 1ns / 1ps

module pltc_back
    import pltc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    input  item_t      pop_item,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] blue_out,
    output logic [7:0] green_out,
    output logic [7:0] red_out,
    output logic       curve_invalid
);

    back_t                 stage_reg [DIV_STAGES+1];
    back_t                 stage0_next;
    logic [DIV_STAGES:0]   stage_valid_reg;
    logic                  out_valid_reg;
    logic [7:0]            red_out_reg;
    logic [7:0]            blue_out_reg;
    logic [7:0]            green_out_reg;
    logic                  invalid_out_reg;
    logic                  advance;

    function automatic div_t start_div(input lane_t l);
        div_t d;
        d.base = l.base;
        d.neg  = l.neg;
        d.den  = l.den;
        d.rem  = PROD_W'(l.mag) * PROD_W'(l.dv);
        d.quo  = '0;
        return d;
    endfunction

    // Negative slope rounds toward minus infinity: subtract the ceiling
    function automatic logic [7:0] finish(input div_t d);
        logic [8:0] q;
        q = {1'b0, d.quo} + 9'(d.neg && d.rem != '0);
        return d.neg ? 8'(d.base - q[7:0]) : 8'(d.base + d.quo);
    endfunction

    // Whole pipeline holds while a finished result waits on a stalled receiver
    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && pop_valid;

    always_comb
    begin
        stage0_next.green   = pop_item.green;
        stage0_next.invalid = pop_item.invalid;
        stage0_next.red     = start_div(pop_item.red);
        stage0_next.blue    = start_div(pop_item.blue);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            stage_reg[0] <= stage0_next;
    end

    genvar s;
    generate
        for (s = 1; s <= DIV_STAGES; s++)
        begin : g_div
            back_t div_next;

            always_comb
            begin
                div_next = stage_reg[s-1];
                for (int b = 0; b < DIV_BITS; b++)
                begin
                    div_next.red  = div_step(div_next.red,
                                             QUO_W - 1 - DIV_BITS * (s - 1) - b);
                    div_next.blue = div_step(div_next.blue,
                                             QUO_W - 1 - DIV_BITS * (s - 1) - b);
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                    stage_reg[s] <= div_next;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            stage_valid_reg <= {stage_valid_reg[DIV_STAGES-1:0], pop_valid};
            out_valid_reg   <= stage_valid_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red_out_reg     <= finish(stage_reg[DIV_STAGES].red);
            blue_out_reg    <= finish(stage_reg[DIV_STAGES].blue);
            green_out_reg   <= stage_reg[DIV_STAGES].green;
            invalid_out_reg <= stage_reg[DIV_STAGES].invalid;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red_out       = red_out_reg;
    assign blue_out      = blue_out_reg;
    assign green_out     = green_out_reg;
    assign curve_invalid = invalid_out_reg;

endmodule

[rtl/piecewise_linear_tone_curve.sv]
// Top level of the piecewise-linear tone curve block.
// Instantiates pltc_front, pltc_fifo and pltc_back; uses pltc_pkg.
`timescale 1ns / 1ps

// Usage:
// - Pixels enter on in_valid/in_stall with blue_in, green_in, red_in; a transfer
//   happens at a clock edge with in_valid high and in_stall low.
// - Results leave on out_valid/out_stall: red and blue mapped through their
//   curves, green unchanged, curve_invalid set (and red/blue passed through)
//   when the x knots do not rise strictly from 0 to 255.
// - Knots are written through cfg_we/cfg_index/cfg_data while the block is
//   idle: index 0 x knots, 1 red knots, 2 blue knots; other indexes ignored.
// - Throughput: one pixel per clock while out_stall is low. A pixel passes from
//   the input transfer to out_valid through the front register, queue, product
//   stage, four divider stages of two quotient bits each and output register.
// - When out_stall is high with a result waiting, the back end holds; the
//   4-entry queue and the front register keep absorbing pixels, and in_stall
//   rises once both are full.
// - Reset (rst_n low, asynchronous) empties all stages and reloads the
//   default knots; no pixel is lost or repeated across a stall.
module piecewise_linear_tone_curve
    import pltc_pkg::*;
#(
    parameter int KNOT_COUNT = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           blue_in,
    input  logic [7:0]           green_in,
    input  logic [7:0]           red_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           blue_out,
    output logic [7:0]           green_out,
    output logic [7:0]           red_out,
    output logic                 curve_invalid
);

    logic  push;
    logic  push_ready;
    item_t push_item;
    logic  pop;
    logic  pop_valid;
    item_t pop_item;

    pltc_front #(
        .KNOT_COUNT (KNOT_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .blue_in    (blue_in),
        .green_in   (green_in),
        .red_in     (red_in),
        .push       (push),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    pltc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item)
    );

    pltc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_item      (pop_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .blue_out      (blue_out),
        .green_out     (green_out),
        .red_out       (red_out),
        .curve_invalid (curve_invalid)
    );

endmodule

[rtl/pltc_checker.sv]
// Port-level checks for piecewise_linear_tone_curve, bound to the top level.
// Tracks pixels in flight from the transfers on both channels. Uses pltc_pkg.
`timescale 1ns / 1ps

module pltc_checker
    import pltc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [7:0]           blue_out,
    input logic [7:0]           green_out,
    input logic [7:0]           red_out,
    input logic                 curve_invalid
);

    localparam int OCC_W = $clog2(OCC_MAX + 1);

    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             in_xfer;
    logic             out_xfer;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;
    assign occ_next = occ_reg + OCC_W'(in_xfer) - OCC_W'(out_xfer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    // A held result keeps its fields
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid &&
            $stable({red_out, green_out, blue_out, curve_invalid}))
        else $error("result changed while stalled");

    // No result without a pixel in flight
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occ_reg != '0)
        else $error("result with no pixel in flight");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(OCC_MAX))
        else $error("more pixels in flight than the pipeline holds");

    // Input stalls only once front register and queue are full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> occ_reg >= OCC_W'(1 + QUEUE_DEPTH))
        else $error("input stalled with room left");

endmodule

bind piecewise_linear_tone_curve pltc_checker u_pltc_checker (.*);

[verif/tb_top.sv]
// Testbench for piecewise_linear_tone_curve: drives BGR pixels and knot writes,
// predicts every result and checks each one in arrival order. Depends on pltc_pkg
// and the RTL top level only.
`timescale 1ns / 1ps

module tb_top;
    import pltc_pkg::*;

    localparam int KNOTS          = 6;
    localparam int HOLD_LEN       = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       invalid;
    } pixel_out_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [7:0]           blue_in   = '0;
    logic [7:0]           green_in  = '0;
    logic [7:0]           red_in    = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           blue_out;
    logic [7:0]           green_out;
    logic [7:0]           red_out;
    logic                 curve_invalid;

    // shadow copy of the knot registers
    logic [REG_W-1:0] cur_x_knots    = X_KNOTS_RESET;
    logic [REG_W-1:0] cur_red_knots  = RED_KNOTS_RESET;
    logic [REG_W-1:0] cur_blue_knots = BLUE_KNOTS_RESET;

    pixel_out_t expected_pixels[$];
    pixel_out_t want_px;
    int         error_count   = 0;
    int         stuck_cycles  = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_seq      = 0;
    int         hold_seen     = 0;
    int         hold_left     = 0;

    piecewise_linear_tone_curve #(.KNOT_COUNT(KNOTS)) u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .blue_in       (blue_in),
        .green_in      (green_in),
        .red_in        (red_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .blue_out      (blue_out),
        .green_out     (green_out),
        .red_out       (red_out),
        .curve_invalid (curve_invalid)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------- prediction ----------------

    function automatic int knot_at(logic [REG_W-1:0] reg_val, int k);
        logic [63:0] ext;
        ext = {16'd0, reg_val};
        if (k < 0 || k > 7)
            return 0;
        return int'(ext[8*k +: 8]);
    endfunction

    function automatic bit curve_usable(logic [REG_W-1:0] xr);
        if (knot_at(xr, 0) != 0 || knot_at(xr, KNOTS - 1) != 255)
            return 1'b0;
        for (int k = 1; k < KNOTS; k++)
            if (knot_at(xr, k) <= knot_at(xr, k - 1))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] curve_value(logic [REG_W-1:0] xr, logic [REG_W-1:0] yr,
                                               int v);
        int j;
        int x0, x1, y0, y1, num, den, q;
        j = 0;
        while (j < KNOTS - 1 && knot_at(xr, j) < v)
            j++;
        x1 = knot_at(xr, j);
        y1 = knot_at(yr, j);
        if (x1 == v || j == 0)
            return 8'(y1);
        x0  = knot_at(xr, j - 1);
        y0  = knot_at(yr, j - 1);
        num = (y1 - y0) * (v - x0);
        den = x1 - x0;
        if (den <= 0)
            return 8'(y1);
        // floor toward minus infinity on falling segments
        if (num >= 0)
            q = num / den;
        else
            q = -((-num + den - 1) / den);
        return 8'(y0 + q);
    endfunction

    function automatic pixel_out_t tone_map_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        pixel_out_t p;
        p.green = g;
        if (!curve_usable(cur_x_knots))
        begin
            p.blue    = b;
            p.red     = r;
            p.invalid = 1'b1;
        end
        else
        begin
            p.blue    = curve_value(cur_x_knots, cur_blue_knots, int'(b));
            p.red     = curve_value(cur_x_knots, cur_red_knots, int'(r));
            p.invalid = 1'b0;
        end
        return p;
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch("result with nothing pending", 0, 0);
            else
            begin
                want_px = expected_pixels.pop_front();
                if (blue_out !== want_px.blue)
                    report_mismatch("blue_out", blue_out, want_px.blue);
                if (green_out !== want_px.green)
                    report_mismatch("green_out", green_out, want_px.green);
                if (red_out !== want_px.red)
                    report_mismatch("red_out", red_out, want_px.red);
                if (curve_invalid !== want_px.invalid)
                    report_mismatch("curve_invalid", curve_invalid, want_px.invalid);
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // ---------------- stimulus helpers ----------------

    // entered and left at a falling edge with nothing assigned yet in that step
    task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
        pixel_out_t p;
        p = tone_map_pixel(b, g, r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        blue_in  <= b;
        green_in <= g;
        red_in   <= r;
        do
            @(posedge clk);
        while (in_stall);
        expected_pixels.push_back(p);
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_pixels.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_X_KNOTS:    cur_x_knots    = data;
            REG_RED_KNOTS:  cur_red_knots  = data;
            REG_BLUE_KNOTS: cur_blue_knots = data;
            default:        ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_curves(input logic [REG_W-1:0] xr, input logic [REG_W-1:0] rr,
                              input logic [REG_W-1:0] br);
        wait_results_drained();
        write_reg(REG_X_KNOTS, xr);
        write_reg(REG_RED_KNOTS, rr);
        write_reg(REG_BLUE_KNOTS, br);
    endtask

    function automatic logic [REG_W-1:0] rand_reg48();
        return REG_W'({$urandom, $urandom});
    endfunction

    function automatic logic [REG_W-1:0] rand_rising_x();
        logic [7:0] k[6];
        k[0] = 8'd0;
        k[5] = 8'd255;
        for (int i = 1; i < 5; i++)
            k[i] = 8'($urandom_range(250 + i, int'(k[i-1]) + 1));
        return {k[5], k[4], k[3], k[2], k[1], k[0]};
    endfunction

    function automatic logic [REG_W-1:0] rand_broken_x();
        logic [REG_W-1:0] xr;
        int               i;
        xr = rand_rising_x();
        case ($urandom_range(3))
            0: xr = rand_reg48();
            1: xr[7:0] = 8'($urandom_range(255, 1));
            2: xr[47:40] = 8'($urandom_range(254));
            default:
            begin
                // repeat or undercut one interior knot
                i = $urandom_range(4, 1);
                xr[8*i +: 8] = xr[8*(i-1) +: 8] - 8'($urandom_range(1));
            end
        endcase
        return xr;
    endfunction

    // mostly uniform, sometimes on or next to a knot
    function automatic logic [7:0] pick_value();
        int v;
        if ($urandom_range(9) < 3)
        begin
            v = knot_at(cur_x_knots, $urandom_range(KNOTS - 1)) + $urandom_range(2) - 1;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            return 8'(v);
        end
        return 8'($urandom_range(255));
    endfunction

    // ---------------- tests ----------------

    task automatic test_default_curves();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd50, 8'h55, 8'd100);
        send_pixel(8'd150, 8'hAA, 8'd200);
        send_pixel(8'd1, 8'h0F, 8'd254);
        send_pixel(8'd49, 8'hF0, 8'd51);
        send_pixel(8'd128, 8'h80, 8'd199);
        send_pixel(8'd201, 8'd1, 8'd149);
    endtask

    task automatic test_curve_shapes();
        // one-wide segments, falling red curve, saturated blue
        set_curves(48'hFF04_0302_0100, 48'h0032_6496_C8FF, 48'hFFFF_FFFF_FFFF);
        send_pixel(8'd0, 8'h3C, 8'd0);
        send_pixel(8'd1, 8'hC3, 8'd2);
        send_pixel(8'd3, 8'h00, 8'd4);
        send_pixel(8'd5, 8'hFF, 8'd128);
        send_pixel(8'd254, 8'h5A, 8'd255);
        // zero red, zig-zag blue
        set_curves(X_KNOTS_RESET, 48'h0, 48'hFF00_FF00_FF00);
        send_pixel(8'd25, 8'd7, 8'd25);
        send_pixel(8'd75, 8'd77, 8'd75);
        send_pixel(8'd199, 8'd200, 8'd201);
    endtask

    task automatic test_invalid_knots();
        set_curves(48'h0, RED_KNOTS_RESET, BLUE_KNOTS_RESET);
        send_pixel(8'd17, 8'd34, 8'd51);
        set_curves(48'hFFFF_FFFF_FFFF, RED_KNOTS_RESET, BLUE_KNOTS_RESET);
        send_pixel(8'd255, 8'd0, 8'd128);
        // first knot not zero
        set_curves(48'hFFC8_9664_3201, RED_KNOTS_RESET, BLUE_KNOTS_RESET);
        send_pixel(8'd0, 8'd255, 8'd1);
        // last knot short of 255
        set_curves(48'hFEC8_9664_3200, RED_KNOTS_RESET, BLUE_KNOTS_RESET);
        send_pixel(8'd255, 8'd128, 8'd254);
        // repeated knot
        set_curves(48'hFFC8_9664_6400, RED_KNOTS_RESET, BLUE_KNOTS_RESET);
        send_pixel(8'd100, 8'd9, 8'd99);
        // knots out of order
        set_curves(48'hFF64_C896_3200, RED_KNOTS_RESET, BLUE_KNOTS_RESET);
        send_pixel(8'd120, 8'd90, 8'd180);
        // write to an unused index must not disturb anything
        set_curves(X_KNOTS_RESET, RED_KNOTS_RESET, BLUE_KNOTS_RESET);
        write_reg(REG_SPARE, 48'h0);
        send_pixel(8'd60, 8'd61, 8'd62);
    endtask

    task automatic test_random_traffic(int send_pct, int recv_pct, int n_cfg, int per_cfg);
        logic [REG_W-1:0] xr;
        logic [REG_W-1:0] rr;
        logic [REG_W-1:0] br;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int c = 0; c < n_cfg; c++)
        begin
            xr = ($urandom_range(99) < 85) ? rand_rising_x() : rand_broken_x();
            rr = rand_reg48();
            br = rand_reg48();
            if (c == 0)
            begin
                rr = 48'h0;
                br = 48'hFFFF_FFFF_FFFF;
            end
            set_curves(xr, rr, br);
            repeat (per_cfg)
                send_pixel(pick_value(), 8'($urandom_range(255)), pick_value());
        end
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_curves(rand_rising_x(), rand_reg48(), rand_reg48());
        hold_seq++;
        repeat (30)
            send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
        // sender pauses until the block has emptied
        wait_results_drained();
        repeat (10)
            send_pixel(pick_value(), 8'($urandom_range(255)), pick_value());
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_curves();
        test_curve_shapes();
        test_invalid_knots();
        test_random_traffic(8, 77, 4, 70);
        test_random_traffic(77, 8, 4, 70);
        test_random_traffic(0, 0, 4, 70);
        test_output_backpressure();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0 && expected_pixels.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
